// File: design/float_to_decimal_text_macros.svh
// assertion macros for the float to decimal text block
// each asserting file needs clk and rst_n in scope
`ifndef FLOAT_TO_DECIMAL_TEXT_MACROS_SVH
`define FLOAT_TO_DECIMAL_TEXT_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define F2DT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define F2DT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define F2DT_ASSERT_NOW(lbl, ante, cons, msg)

`define F2DT_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// File: design/f2dt_pkg.sv
`timescale 1ns / 1ps

package f2dt_pkg;

    // fraction digits kept after the point (1 to 9)
    localparam int FRAC_DIGITS = 6;
    localparam longint FRAC_SCALE = 64'(10) ** FRAC_DIGITS;
    localparam int FRAC_W = $clog2(FRAC_SCALE);

    localparam int MAN_W = 24;
    localparam int PROD_W = MAN_W + FRAC_W;
    localparam int INT_DIGITS = 10;
    // counter wide enough for the integer digit count and the fraction digit count
    localparam int CNT_W = $clog2(INT_DIGITS + 1);

    localparam logic [7:0] EXP_SAT = 8'd159;
    localparam logic [7:0] EXP_NO_FRAC = 8'd150;
    localparam logic [7:0] SUBN_SHIFT = 8'd149;
    localparam logic [MAN_W-1:0] MAN_ONES = '1;

    localparam logic [31:0] RECIP10 = 32'hCCCC_CCCD;
    localparam int RECIP10_SH = 35;

    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT = 8'h2E;

    localparam int Q_DEPTH = 2;
    localparam int Q_PW = $clog2(Q_DEPTH);

    // one decomposed number on its way to the text generator
    typedef struct packed {
        logic              neg;
        logic              oor;
        logic [31:0]       ipart;
        logic [FRAC_W-1:0] fdig;
    } f2dt_rec_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_LOAD,
        BK_INT,
        BK_FRAC,
        BK_SIGN,
        BK_IDIG,
        BK_DOT,
        BK_FDIG
    } back_state_t;

endpackage

// File: design/f2dt_front.sv
`timescale 1ns / 1ps

module f2dt_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [31:0]       value_bits,
    input  f2dt_pkg::q_stat_t qstat,
    output logic              busy,
    output logic              push,
    output f2dt_pkg::f2dt_rec_t rec
);
    import f2dt_pkg::*;

    logic              accept;
    logic              sign;
    logic [7:0]        expf;
    logic [22:0]       man;
    logic              is_nan;
    logic [MAN_W-1:0]  m;
    logic [3:0]        lsh;

    logic              neg_c;
    logic              oor_c;
    logic [31:0]       ipart_c;
    logic [MAN_W-1:0]  fbits_c;
    logic [7:0]        sh_c;

    logic              va_reg;
    logic              vb_reg;
    logic              neg_a_reg;
    logic              oor_a_reg;
    logic [31:0]       ipart_a_reg;
    logic [MAN_W-1:0]  fbits_a_reg;
    logic [7:0]        sh_a_reg;
    logic              neg_b_reg;
    logic              oor_b_reg;
    logic [31:0]       ipart_b_reg;
    logic [7:0]        sh_b_reg;
    logic [PROD_W-1:0] prod_reg;

    assign busy   = va_reg | vb_reg | qstat.full;
    assign accept = start & ~busy;

    // classify and split into integer and fraction bits
    always_comb
    begin
        sign    = value_bits[31];
        expf    = value_bits[30:23];
        man     = value_bits[22:0];
        is_nan  = (expf == 8'hFF) && (man != 23'd0);
        neg_c   = sign && !is_nan && (value_bits[30:0] != 31'd0);
        m       = (expf == 8'd0) ? {1'b0, man} : {1'b1, man};
        lsh     = 4'(expf - EXP_NO_FRAC);
        oor_c   = 1'b0;
        ipart_c = '0;
        fbits_c = '0;
        sh_c    = '0;
        priority if (expf >= EXP_SAT)
        begin
            oor_c   = 1'b1;
            ipart_c = '1;
        end
        else if (expf >= EXP_NO_FRAC)
        begin
            ipart_c = {8'd0, m} << lsh;
        end
        else
        begin
            sh_c    = (expf == 8'd0) ? SUBN_SHIFT : 8'(EXP_NO_FRAC - expf);
            ipart_c = {8'd0, m >> sh_c};
            fbits_c = m & ~(MAN_ONES << sh_c);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end
        else
        begin
            va_reg <= accept;
            vb_reg <= va_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            neg_a_reg   <= neg_c;
            oor_a_reg   <= oor_c;
            ipart_a_reg <= ipart_c;
            fbits_a_reg <= fbits_c;
            sh_a_reg    <= sh_c;
        end
        if (va_reg)
        begin
            neg_b_reg   <= neg_a_reg;
            oor_b_reg   <= oor_a_reg;
            ipart_b_reg <= ipart_a_reg;
            sh_b_reg    <= sh_a_reg;
            prod_reg    <= PROD_W'(fbits_a_reg) * PROD_W'(FRAC_SCALE);
        end
    end

    // truncated fraction digits as one binary number
    assign push      = vb_reg;
    assign rec.neg   = neg_b_reg;
    assign rec.oor   = oor_b_reg;
    assign rec.ipart = ipart_b_reg;
    assign rec.fdig  = FRAC_W'(prod_reg >> sh_b_reg);

endmodule

// File: design/f2dt_queue.sv
`timescale 1ns / 1ps

module f2dt_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  f2dt_pkg::f2dt_rec_t push_rec,
    input  logic                pop,
    output f2dt_pkg::f2dt_rec_t pop_rec,
    output f2dt_pkg::q_stat_t   qstat
);
    import f2dt_pkg::*;

    f2dt_rec_t       mem [Q_DEPTH];
    f2dt_rec_t       rd_reg;
    logic [Q_PW-1:0] wr_ptr_reg;
    logic [Q_PW-1:0] rd_ptr_reg;
    logic [Q_PW:0]   cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= Q_PW'((Q_PW + 1)'(wr_ptr_reg) + 1'b1);
            if (pop)
                rd_ptr_reg <= Q_PW'((Q_PW + 1)'(rd_ptr_reg) + 1'b1);
            unique case ({push, pop})
                2'b10:   cnt_reg <= cnt_reg + 1'b1;
                2'b01:   cnt_reg <= cnt_reg - 1'b1;
                default: cnt_reg <= cnt_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_rec;
        if (pop)
            rd_reg <= mem[rd_ptr_reg];
    end

    assign pop_rec     = rd_reg;
    assign qstat.full  = (cnt_reg == (Q_PW + 1)'(Q_DEPTH));
    assign qstat.empty = (cnt_reg == '0);

endmodule

// File: design/f2dt_back.sv
`timescale 1ns / 1ps

module f2dt_back (
    input  logic                clk,
    input  logic                rst_n,
    input  f2dt_pkg::q_stat_t   qstat,
    input  f2dt_pkg::f2dt_rec_t pop_rec,
    output logic                pop,
    output logic                valid,
    output logic [7:0]          char_code,
    output logic                last_char,
    output logic                out_of_range
);
    import f2dt_pkg::*;

    back_state_t       st_reg, st_next;
    logic [31:0]       x_reg, x_next;
    logic [FRAC_W-1:0] fsave_reg, fsave_next;
    logic              neg_reg, neg_next;
    logic              oor_reg, oor_next;
    logic [CNT_W-1:0]  ndig_reg, ndig_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [CNT_W-1:0]  flen_reg, flen_next;
    logic              seen_reg, seen_next;
    logic [3:0]        ibuf_reg [INT_DIGITS];
    logic [3:0]        ibuf_next [INT_DIGITS];
    logic [3:0]        fbuf_reg [FRAC_DIGITS];
    logic [3:0]        fbuf_next [FRAC_DIGITS];
    logic              ovalid_reg, ovalid_next;
    logic [7:0]        ochar_reg, ochar_next;
    logic              olast_reg, olast_next;
    logic              ooor_reg, ooor_next;

    logic [63:0]       dv_prod;
    logic [31:0]       dv_q;
    logic [31:0]       dv_r;
    logic [3:0]        digit;

    // divide by ten through the reciprocal, one digit per cycle
    assign dv_prod = {32'd0, x_reg} * {32'd0, RECIP10};
    assign dv_q    = {3'd0, dv_prod[63:RECIP10_SH]};
    assign dv_r    = x_reg - ((dv_q << 3) + (dv_q << 1));
    assign digit   = dv_r[3:0];

    always_comb
    begin
        st_next = st_reg;
        unique case (st_reg)
            BK_IDLE: if (!qstat.empty) st_next = BK_LOAD;
            BK_LOAD: st_next = BK_INT;
            BK_INT:  if (dv_q == 32'd0) st_next = BK_FRAC;
            BK_FRAC:
            begin
                if (cnt_reg == CNT_W'(FRAC_DIGITS - 1))
                    st_next = neg_reg ? BK_SIGN : BK_IDIG;
            end
            BK_SIGN: st_next = BK_IDIG;
            BK_IDIG: if (ndig_reg == CNT_W'(1)) st_next = BK_DOT;
            BK_DOT:  st_next = BK_FDIG;
            BK_FDIG: if (flen_reg == CNT_W'(1)) st_next = BK_IDLE;
            default: st_next = BK_IDLE;
        endcase
    end

    always_comb
    begin
        pop         = 1'b0;
        x_next      = x_reg;
        fsave_next  = fsave_reg;
        neg_next    = neg_reg;
        oor_next    = oor_reg;
        ndig_next   = ndig_reg;
        cnt_next    = cnt_reg;
        flen_next   = flen_reg;
        seen_next   = seen_reg;
        ibuf_next   = ibuf_reg;
        fbuf_next   = fbuf_reg;
        ovalid_next = 1'b0;
        ochar_next  = ochar_reg;
        olast_next  = 1'b0;
        ooor_next   = ooor_reg;
        unique case (st_reg)
            BK_IDLE:
            begin
                pop = !qstat.empty;
            end
            BK_LOAD:
            begin
                x_next     = pop_rec.ipart;
                fsave_next = pop_rec.fdig;
                neg_next   = pop_rec.neg;
                oor_next   = pop_rec.oor;
                ndig_next  = '0;
            end
            BK_INT:
            begin
                // newest digit at slot 0, so slot 0 ends as the leading digit
                for (int k = INT_DIGITS - 1; k > 0; k--)
                    ibuf_next[k] = ibuf_reg[k-1];
                ibuf_next[0] = digit;
                ndig_next    = ndig_reg + 1'b1;
                x_next       = dv_q;
                if (dv_q == 32'd0)
                begin
                    x_next    = 32'(fsave_reg);
                    cnt_next  = '0;
                    flen_next = CNT_W'(1);
                    seen_next = 1'b0;
                end
            end
            BK_FRAC:
            begin
                for (int k = FRAC_DIGITS - 1; k > 0; k--)
                    fbuf_next[k] = fbuf_reg[k-1];
                fbuf_next[0] = digit;
                // first nonzero digit from the low end sets the kept length
                if (digit != 4'd0 && !seen_reg)
                begin
                    flen_next = CNT_W'(FRAC_DIGITS) - cnt_reg;
                    seen_next = 1'b1;
                end
                cnt_next = cnt_reg + 1'b1;
                x_next   = dv_q;
            end
            BK_SIGN:
            begin
                ovalid_next = 1'b1;
                ochar_next  = CH_MINUS;
                ooor_next   = oor_reg;
            end
            BK_IDIG:
            begin
                ovalid_next = 1'b1;
                ochar_next  = CH_ZERO + {4'd0, ibuf_reg[0]};
                ooor_next   = oor_reg;
                for (int k = 0; k < INT_DIGITS - 1; k++)
                    ibuf_next[k] = ibuf_reg[k+1];
                ndig_next = ndig_reg - 1'b1;
            end
            BK_DOT:
            begin
                ovalid_next = 1'b1;
                ochar_next  = CH_DOT;
                ooor_next   = oor_reg;
            end
            BK_FDIG:
            begin
                ovalid_next = 1'b1;
                ochar_next  = CH_ZERO + {4'd0, fbuf_reg[0]};
                olast_next  = (flen_reg == CNT_W'(1));
                ooor_next   = oor_reg;
                for (int k = 0; k < FRAC_DIGITS - 1; k++)
                    fbuf_next[k] = fbuf_reg[k+1];
                flen_next = flen_reg - 1'b1;
            end
            default:
            begin
                pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg     <= BK_IDLE;
            ovalid_reg <= 1'b0;
            olast_reg  <= 1'b0;
        end
        else
        begin
            st_reg     <= st_next;
            ovalid_reg <= ovalid_next;
            olast_reg  <= olast_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg     <= x_next;
        fsave_reg <= fsave_next;
        neg_reg   <= neg_next;
        oor_reg   <= oor_next;
        ndig_reg  <= ndig_next;
        cnt_reg   <= cnt_next;
        flen_reg  <= flen_next;
        seen_reg  <= seen_next;
        ibuf_reg  <= ibuf_next;
        fbuf_reg  <= fbuf_next;
        ochar_reg <= ochar_next;
        ooor_reg  <= ooor_next;
    end

    assign valid        = ovalid_reg;
    assign char_code    = ochar_reg;
    assign last_char    = olast_reg;
    assign out_of_range = ooor_reg;

endmodule

// File: design/float_to_decimal_text.sv
`timescale 1ns / 1ps
// channel   signals                                    handshake
// input     value_bits                                 start high, busy low at the edge
// result    char_code, last_char, out_of_range         valid high with each character, no stall
//
// the front classifies a value and registers it at the accepting edge, then registers the scaled fraction and queues it
// the text generator pops and loads a value, takes the integer digits (divide by ten with a
// 32x32 reciprocal multiply), then the FRAC_DIGITS fraction digits, and sends the sign (if
// negative), the integer digits, the point and the kept fraction digits as characters; a
// two-deep queue lets the front take the next value
// reset clears control state only; busy is high while the front holds a value and when full

module float_to_decimal_text (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] value_bits,
    output logic        busy,
    output logic        valid,
    output logic [7:0]  char_code,
    output logic        last_char,
    output logic        out_of_range
);
    import f2dt_pkg::*;

    `include "float_to_decimal_text_macros.svh"

    // front to queue
    logic      push;
    f2dt_rec_t push_rec;

    // queue to text generator
    logic      pop;
    f2dt_rec_t pop_rec;
    q_stat_t   qstat;

    // sign, saturation, exact fixed-point split and fraction scaling
    f2dt_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .value_bits (value_bits),
        .qstat      (qstat),
        .busy       (busy),
        .push       (push),
        .rec        (push_rec)
    );

    // decouples the front from character output
    f2dt_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_rec (push_rec),
        .pop      (pop),
        .pop_rec  (pop_rec),
        .qstat    (qstat)
    );

    // digit conversion and character sequencing
    f2dt_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .qstat        (qstat),
        .pop_rec      (pop_rec),
        .pop          (pop),
        .valid        (valid),
        .char_code    (char_code),
        .last_char    (last_char),
        .out_of_range (out_of_range)
    );

    // an accepted transaction keeps the front occupied on the next cycle
    `F2DT_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "front free after accept")
    // the queue never takes a transaction while full
    `F2DT_ASSERT_NOW(a_no_overflow, push, !qstat.full, "push into full queue")
    // the final character is followed by a gap before the next text
    `F2DT_ASSERT_NEXT(a_last_gap, valid && last_char, !valid, "character after last")

endmodule
